// ===== hw/rtl/psfc_pkg.sv =====
// ----------------------------------------------------------------------------
// psfc_pkg
// Shared types and constants of the particle sensor reply frame checker.
// ----------------------------------------------------------------------------
package psfc_pkg;

  // frame layout
  localparam int unsigned FRAME_BYTES = 8;

  // header bytes that open a valid frame
  localparam logic [7:0] HDR0 = 8'h40;
  localparam logic [7:0] HDR1 = 8'h05;
  localparam logic [7:0] HDR2 = 8'h04;

  // readings reported before the first good frame
  localparam logic [15:0] RESET_READING = 16'd50;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_NO_HEADER    = 2'd1,
    STATUS_BAD_CHECKSUM = 2'd2
  } psfc_status_e;

  // control from the byte stage to the evaluation stage
  typedef struct packed {
    logic fire;  // stage holds a byte that moves on this cycle
    logic eor;   // that byte closes the reply
  } psfc_step_t;

endpackage

// ===== hw/rtl/psfc_in_if.sv =====
// ----------------------------------------------------------------------------
// psfc_in_if
// Received byte channel: one reply byte per transaction plus end-of-reply flag.
// ----------------------------------------------------------------------------
interface psfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_reply;

  modport source (output valid, output rx_byte, output end_of_reply, input ready);
  modport sink   (input valid, input rx_byte, input end_of_reply, output ready);
endinterface

// ===== hw/rtl/psfc_out_if.sv =====
// ----------------------------------------------------------------------------
// psfc_out_if
// Result channel: readings and status, one transaction per evaluated reply.
// ----------------------------------------------------------------------------
interface psfc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] fine_reading;
  logic [15:0] coarse_reading;
  logic [1:0]  status;

  modport source (output valid, output fine_reading, output coarse_reading,
                  output status, input ready);
  modport sink   (input valid, input fine_reading, input coarse_reading,
                  input status, output ready);
endinterface

// ===== hw/rtl/psfc_buffer.sv =====
// ----------------------------------------------------------------------------
// psfc_buffer
// Input register and reply buffer; presents the frame including the held byte.
// ----------------------------------------------------------------------------
module psfc_buffer import psfc_pkg::*; #(
  parameter int unsigned REPLY_BYTES = 10,
  localparam int unsigned CNT_W = $clog2(REPLY_BYTES + 1)
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_eor_i,
  output logic       in_ready_o,
  input  logic       out_free_i,
  output psfc_step_t step_o,
  output logic [7:0] frame_o [REPLY_BYTES]
);

  logic             vld_q;
  logic [7:0]       byte_q;
  logic             eor_q;
  logic [CNT_W-1:0] cnt_q;
  logic [7:0]       buf_q [REPLY_BYTES];
  logic             stage_go;

  // held byte moves on unless it closes a reply and the result slot is busy
  assign stage_go   = vld_q && (!eor_q || out_free_i);
  assign in_ready_o = !vld_q || stage_go;

  assign step_o.fire = stage_go;
  assign step_o.eor  = eor_q;

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
      eor_q  <= in_eor_i;
    end
  end

  // buffer with the held byte written at the fill position, if room remains
  always_comb begin
    for (int i = 0; i < REPLY_BYTES; i++) begin
      frame_o[i] = (vld_q && cnt_q == CNT_W'(i)) ? byte_q : buf_q[i];
    end
  end

  // reply buffer and fill count, cleared after each reply
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < REPLY_BYTES; i++) begin
        buf_q[i] <= 8'd0;
      end
    end else if (stage_go) begin
      if (eor_q) begin
        cnt_q <= '0;
        for (int i = 0; i < REPLY_BYTES; i++) begin
          buf_q[i] <= 8'd0;
        end
      end else begin
        for (int i = 0; i < REPLY_BYTES; i++) begin
          buf_q[i] <= frame_o[i];
        end
        if (cnt_q != CNT_W'(REPLY_BYTES)) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
    end
  end

`ifndef SYNTHESIS
  // fill count never passes the buffer depth
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(REPLY_BYTES))
    else $error("psfc_buffer: fill count beyond buffer depth");

  // a closing byte leaves an empty buffer
  a_cnt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_go && eor_q |=> cnt_q == '0)
    else $error("psfc_buffer: buffer not cleared after reply");

  // a byte that cannot move on stays in the input register
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && !stage_go |=> vld_q && $stable(byte_q) && $stable(eor_q))
    else $error("psfc_buffer: stalled byte lost");
`endif

endmodule

// ===== hw/rtl/psfc_eval.sv =====
// ----------------------------------------------------------------------------
// psfc_eval
// Header search and checksum on the frame, last good readings, result register.
// ----------------------------------------------------------------------------
module psfc_eval import psfc_pkg::*; #(
  parameter int unsigned REPLY_BYTES = 10,
  localparam int unsigned N_OFF = REPLY_BYTES - FRAME_BYTES + 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  psfc_step_t   step_i,
  input  logic [7:0]   frame_i [REPLY_BYTES],
  output logic         out_free_o,
  output logic         res_valid_o,
  input  logic         res_ready_i,
  output logic [15:0]  fine_o,
  output logic [15:0]  coarse_o,
  output logic [1:0]   status_o
);

  logic         hit  [N_OFF];
  logic         good [N_OFF];
  logic         found;
  logic         sel_good;
  logic [15:0]  sel_fine;
  logic [15:0]  sel_coarse;
  psfc_status_e status_d;
  logic         result_go;

  logic         out_vld_q;
  logic [15:0]  fine_q;
  logic [15:0]  coarse_q;
  psfc_status_e status_q;
  logic [15:0]  last_fine_q;
  logic [15:0]  last_coarse_q;

  // header and checksum test at every candidate offset
  always_comb begin
    logic [7:0] sum;
    for (int k = 0; k < N_OFF; k++) begin
      hit[k] = frame_i[k] == HDR0 && frame_i[k+1] == HDR1 && frame_i[k+2] == HDR2;
      sum = 8'd0;
      for (int j = 0; j < FRAME_BYTES - 1; j++) begin
        sum = sum + frame_i[k+j];
      end
      good[k] = frame_i[k+7] != 8'd0 && 8'(sum + frame_i[k+7]) == 8'd0;
    end
  end

  // lowest matching offset wins
  always_comb begin
    found      = 1'b0;
    sel_good   = 1'b0;
    sel_fine   = 16'd0;
    sel_coarse = 16'd0;
    for (int k = N_OFF - 1; k >= 0; k--) begin
      if (hit[k]) begin
        found      = 1'b1;
        sel_good   = good[k];
        sel_fine   = {frame_i[k+3], frame_i[k+4]};
        sel_coarse = {frame_i[k+5], frame_i[k+6]};
      end
    end
  end

  always_comb begin
    priority if (!found) begin
      status_d = STATUS_NO_HEADER;
    end else if (!sel_good) begin
      status_d = STATUS_BAD_CHECKSUM;
    end else begin
      status_d = STATUS_OK;
    end
  end

  assign result_go  = step_i.fire && step_i.eor;
  assign out_free_o = !out_vld_q || res_ready_i;

  // result valid and last good readings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q     <= 1'b0;
      last_fine_q   <= RESET_READING;
      last_coarse_q <= RESET_READING;
    end else begin
      if (result_go) begin
        out_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (result_go && status_d == STATUS_OK) begin
        last_fine_q   <= sel_fine;
        last_coarse_q <= sel_coarse;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (result_go) begin
      status_q <= status_d;
      if (status_d == STATUS_OK) begin
        fine_q   <= sel_fine;
        coarse_q <= sel_coarse;
      end else begin
        fine_q   <= last_fine_q;
        coarse_q <= last_coarse_q;
      end
    end
  end

  assign res_valid_o = out_vld_q;
  assign fine_o      = fine_q;
  assign coarse_o    = coarse_q;
  assign status_o    = status_q;

`ifndef SYNTHESIS
  // a shown result always carries the readings kept at that moment
  a_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> fine_q == last_fine_q && coarse_q == last_coarse_q)
    else $error("psfc_eval: result readings differ from kept readings");

  // a closing byte always yields a result next cycle
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_go |=> out_vld_q)
    else $error("psfc_eval: reply evaluated without result");

  // a result that is not taken stays unchanged
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res_ready_i |=> out_vld_q && $stable(fine_q) &&
      $stable(coarse_q) && $stable(status_q))
    else $error("psfc_eval: stalled result changed");
`endif

endmodule

// ===== hw/rtl/particle_sensor_frame_check_top.sv =====
// A reply's final byte is registered in the input register on acceptance, and its
// result is registered in the result register once the result slot is free.
// Throughput: one byte per cycle; a closing byte waits only while an unread
// result holds the output, and the frame check fits in the single stage.
// Reset clears the buffer and fill count and sets the kept readings to 50.
// ----------------------------------------------------------------------------
// particle_sensor_frame_check_top
// Collects sensor reply bytes, checks header and checksum, reports readings.
// ----------------------------------------------------------------------------
module particle_sensor_frame_check_top import psfc_pkg::*; #(
  parameter int unsigned REPLY_BYTES = 10
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  psfc_in_if.sink    rx_i,
  psfc_out_if.source res_o
);

  psfc_step_t step;
  logic [7:0] frame [REPLY_BYTES];
  logic       out_free;

  // byte collection
  psfc_buffer #(
    .REPLY_BYTES (REPLY_BYTES)
  ) u_buffer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_byte_i  (rx_i.rx_byte),
    .in_eor_i   (rx_i.end_of_reply),
    .in_ready_o (rx_i.ready),
    .out_free_i (out_free),
    .step_o     (step),
    .frame_o    (frame)
  );

  // frame check and result
  psfc_eval #(
    .REPLY_BYTES (REPLY_BYTES)
  ) u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .frame_i     (frame),
    .out_free_o  (out_free),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .fine_o      (res_o.fine_reading),
    .coarse_o    (res_o.coarse_reading),
    .status_o    (res_o.status)
  );

endmodule
